// ===== src/sdc_pkg.sv =====
// ----------------------------------------------------------------------------
// SASI disk controller package
// Shared types, codes and sizes of the disk controller block.
// ----------------------------------------------------------------------------
package sdc_pkg;

   localparam int SECTOR_BYTES = 256;
   localparam int POS_W        = $clog2(SECTOR_BYTES) + 1;
   localparam int ADDR_W       = $clog2(SECTOR_BYTES);

   // Input operations.
   localparam logic [2:0] OP_BUS_WRITE = 3'd0;
   localparam logic [2:0] OP_BUS_READ  = 3'd1;
   localparam logic [2:0] OP_TICK      = 3'd2;
   localparam logic [2:0] OP_FILL      = 3'd3;
   localparam logic [2:0] OP_DONE      = 3'd4;

   // Bus ports.
   localparam logic [1:0] PORT_DATA   = 2'd0;
   localparam logic [1:0] PORT_STATUS = 2'd1;
   localparam logic [1:0] PORT_SELECT = 2'd2;
   localparam logic [1:0] PORT_MASK   = 2'd3;

   // Disk request codes.
   localparam logic [1:0] DCMD_NONE   = 2'd0;
   localparam logic [1:0] DCMD_READ   = 2'd1;
   localparam logic [1:0] DCMD_WRITE  = 2'd2;
   localparam logic [1:0] DCMD_FORMAT = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_DRIVE_PRESENT = 1'b0;
   localparam logic CSR_EVENT_DELAY   = 1'b1;

   typedef struct packed {
      logic [2:0] operation;
      logic [1:0] port;
      logic [7:0] wdata;
      logic [7:0] fill_index;
      logic [7:0] fill_byte;
      logic       disk_ok;
   } req_type;

   typedef struct packed {
      logic [7:0]  rdata;
      logic        irq_pulse;
      logic        drq;
      logic [1:0]  disk_cmd;
      logic        disk_unit;
      logic [20:0] disk_sector;
      logic [7:0]  disk_byte_index;
      logic [7:0]  disk_wdata;
   } rsp_type;

   // Write and clear request from the sequencer to the sector buffer.
   typedef struct packed {
      logic              clr;
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [7:0]        wdata;
   } buf_req_type;

endpackage

// ===== src/sdc_buffer.sv =====
// ----------------------------------------------------------------------------
// SASI disk controller sector buffer
// Sector RAM with per-byte valid bits and a prefetched read of the byte at
// the current buffer position.
// ----------------------------------------------------------------------------
module sdc_buffer (
   input  logic                       clock,
   input  logic                       reset,
   input  sdc_pkg::buf_req_type       buf_req,
   input  logic [sdc_pkg::POS_W-1:0]  pos_nxt,
   output logic [7:0]                 rd_byte
);
   import sdc_pkg::*;

   logic [7:0]        mem [SECTOR_BYTES];
   logic [SECTOR_BYTES-1:0] valid_ff;
   logic [7:0]        pf_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [ADDR_W-1:0] raddr;

   assign raddr = pos_nxt[ADDR_W-1:0];

   // RAM write and registered read, with the same-cycle write forwarded.
   always_ff @(posedge clock) begin
      if (buf_req.we) begin
         mem[buf_req.waddr] <= buf_req.wdata;
      end
      if (buf_req.we && (buf_req.waddr == raddr)) begin
         pf_ff <= buf_req.wdata;
      end else begin
         pf_ff <= mem[raddr];
      end
      addr_ff <= raddr;
   end

   // Valid bits: a clear empties the whole buffer at once.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (buf_req.clr) begin
         valid_ff <= '0;
      end else if (buf_req.we) begin
         valid_ff[buf_req.waddr] <= 1'b1;
      end
   end

   // A byte never written since the last clear reads as zero.
   assign rd_byte = valid_ff[addr_ff] ? pf_ff : 8'd0;

endmodule

// ===== src/sdc_core.sv =====
// ----------------------------------------------------------------------------
// SASI disk controller sequencer
// Bus phases, command decode, counters, timer event and disk requests; one
// word is processed in each step.
// ----------------------------------------------------------------------------
module sdc_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  sdc_pkg::req_type           req,
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [15:0]                csr_wdata,
   input  logic [7:0]                 rd_byte,
   output sdc_pkg::buf_req_type       buf_req,
   output logic [sdc_pkg::POS_W-1:0]  pos_nxt,
   output sdc_pkg::rsp_type           rsp
);
   import sdc_pkg::*;

   localparam logic [3:0] PH_FREE     = 4'd0;
   localparam logic [3:0] PH_SELECT   = 4'd1;
   localparam logic [3:0] PH_COMMAND  = 4'd2;
   localparam logic [3:0] PH_C2       = 4'd3;
   localparam logic [3:0] PH_SENSE    = 4'd4;
   localparam logic [3:0] PH_READ     = 4'd5;
   localparam logic [3:0] PH_WRITE    = 4'd6;
   localparam logic [3:0] PH_STATUS   = 4'd7;
   localparam logic [3:0] PH_DISKWAIT = 4'd8;

   localparam logic [1:0] EV_NONE    = 2'd0;
   localparam logic [1:0] EV_COMMAND = 2'd1;
   localparam logic [1:0] EV_STATUS  = 2'd2;

   localparam logic [1:0] WK_NONE   = 2'd0;
   localparam logic [1:0] WK_START  = 2'd1;
   localparam logic [1:0] WK_NEXT   = 2'd2;
   localparam logic [1:0] WK_FORMAT = 2'd3;

   localparam logic [7:0] CMD_TEST   = 8'h00;
   localparam logic [7:0] CMD_RECAL  = 8'h01;
   localparam logic [7:0] CMD_SENSE  = 8'h03;
   localparam logic [7:0] CMD_FMTDRV = 8'h04;
   localparam logic [7:0] CMD_FMTTRK = 8'h06;
   localparam logic [7:0] CMD_READ   = 8'h08;
   localparam logic [7:0] CMD_WRITE  = 8'h0a;
   localparam logic [7:0] CMD_SEEK   = 8'h0b;
   localparam logic [7:0] CMD_C2     = 8'hc2;

   localparam logic [7:0] ERR_NONE    = 8'h00;
   localparam logic [7:0] ERR_DISK    = 8'h0f;
   localparam logic [7:0] ERR_NOTRDY  = 8'h7f;

   localparam logic [POS_W-1:0] POS_END = POS_W'(SECTOR_BYTES);

   // Configuration registers.
   logic [1:0]  drive_present_ff;
   logic [15:0] event_delay_ff;

   // Controller state.
   logic [3:0]       phase_ff, phase_in;
   logic [7:0]       cmd_ff [6];
   logic [7:0]       cmd_in [6];
   logic [2:0]       ccount_ff, ccount_in;
   logic             sel_ff, sel_in;
   logic [20:0]      cur_ff, cur_in;
   logic [7:0]       blocks_ff, blocks_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       err_ff, err_in;
   logic [7:0]       sense_ff [4];
   logic [7:0]       sense_in [4];
   logic [3:0]       spos_ff, spos_in;
   logic             irq_ff, irq_in;
   logic             drq_ff, drq_in;
   logic [7:0]       mask_ff, mask_in;
   logic [1:0]       pev_ff, pev_in;
   logic [15:0]      count_ff, count_in;
   logic [1:0]       wk_ff, wk_in;
   logic             owed_ff, owed_in;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         drive_present_ff <= 2'd0;
         event_delay_ff   <= 16'd10;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DRIVE_PRESENT: drive_present_ff <= csr_wdata[1:0];
            CSR_EVENT_DELAY:   event_delay_ff   <= csr_wdata;
            default:           ;
         endcase
      end
   end

   // Next state and result of one step.
   always_comb begin
      logic       ut;
      logic       fin;
      logic [7:0] fin_code;
      logic       clr;
      logic [7:0] sbits;

      phase_in  = phase_ff;
      cmd_in    = cmd_ff;
      ccount_in = ccount_ff;
      sel_in    = sel_ff;
      cur_in    = cur_ff;
      blocks_in = blocks_ff;
      pos_in    = pos_ff;
      err_in    = err_ff;
      sense_in  = sense_ff;
      spos_in   = spos_ff;
      irq_in    = irq_ff;
      drq_in    = drq_ff;
      mask_in   = mask_ff;
      pev_in    = pev_ff;
      count_in  = count_ff;
      wk_in     = wk_ff;
      owed_in   = owed_ff;
      rsp       = '0;
      buf_req   = '0;
      ut        = 1'b0;
      fin       = 1'b0;
      fin_code  = ERR_NONE;
      clr       = 1'b0;
      sbits     = 8'd0;

      case (req.operation)
         OP_BUS_WRITE: begin
            case (req.port)
               PORT_DATA: begin
                  if (phase_ff == PH_COMMAND) begin
                     if (ccount_ff < 3'd6) begin
                        cmd_in[ccount_ff] = req.wdata;
                        ccount_in         = ccount_ff + 3'd1;
                        if (ccount_in == 3'd6) begin
                           // All six command bytes are in: run the command.
                           sel_in = cmd_in[1][5];
                           ut     = drive_present_ff[sel_in];
                           case (cmd_in[0])
                              CMD_TEST: begin
                                 fin      = 1'b1;
                                 fin_code = ut ? ERR_NONE : ERR_NOTRDY;
                              end
                              CMD_RECAL: begin
                                 if (ut) begin
                                    cur_in = 21'd0;
                                 end
                                 fin      = 1'b1;
                                 fin_code = ut ? ERR_NONE : ERR_NOTRDY;
                              end
                              CMD_SENSE: begin
                                 phase_in    = PH_SENSE;
                                 sense_in[0] = err_ff;
                                 sense_in[1] = {2'b00, sel_in, cur_ff[20:16]};
                                 sense_in[2] = cur_ff[15:8];
                                 sense_in[3] = cur_ff[7:0];
                                 err_in      = ERR_NONE;
                                 spos_in     = 4'd0;
                              end
                              CMD_FMTDRV: begin
                                 cur_in   = 21'd0;
                                 fin      = 1'b1;
                                 fin_code = ERR_DISK;
                              end
                              CMD_FMTTRK: begin
                                 cur_in    = {cmd_in[1][4:0], cmd_in[2], cmd_in[3]};
                                 blocks_in = cmd_in[4];
                                 if (ut) begin
                                    clr                 = 1'b1;
                                    phase_in            = PH_DISKWAIT;
                                    wk_in               = WK_FORMAT;
                                    rsp.disk_cmd        = DCMD_FORMAT;
                                    rsp.disk_unit       = sel_in;
                                    rsp.disk_sector     = cur_in;
                                 end else begin
                                    fin      = 1'b1;
                                    fin_code = ERR_DISK;
                                 end
                              end
                              CMD_READ, CMD_WRITE: begin
                                 cur_in    = {cmd_in[1][4:0], cmd_in[2], cmd_in[3]};
                                 blocks_in = cmd_in[4];
                                 if (blocks_in == 8'd0) begin
                                    fin      = 1'b1;
                                    fin_code = ERR_DISK;
                                 end else begin
                                    clr = 1'b1;
                                    if (ut) begin
                                       phase_in = PH_DISKWAIT;
                                       wk_in    = WK_START;
                                       owed_in  = 1'b1;
                                    end else begin
                                       fin      = 1'b1;
                                       fin_code = ERR_DISK;
                                    end
                                 end
                              end
                              CMD_SEEK: begin
                                 cur_in    = {cmd_in[1][4:0], cmd_in[2], cmd_in[3]};
                                 blocks_in = cmd_in[4];
                                 fin       = 1'b1;
                                 fin_code  = ERR_NONE;
                              end
                              CMD_C2: begin
                                 phase_in = PH_C2;
                                 spos_in  = 4'd0;
                              end
                              default: begin
                                 fin      = 1'b1;
                                 fin_code = ERR_NONE;
                              end
                           endcase
                        end
                     end
                  end else if (phase_ff == PH_C2) begin
                     if (spos_ff < 4'd10) begin
                        spos_in = spos_ff + 4'd1;
                        if (spos_in == 4'd10) begin
                           fin      = 1'b1;
                           fin_code = ERR_NONE;
                        end
                     end
                  end else if (phase_ff == PH_WRITE) begin
                     if (pos_ff < POS_END) begin
                        buf_req.we    = 1'b1;
                        buf_req.waddr = pos_ff[ADDR_W-1:0];
                        buf_req.wdata = req.wdata;
                        if (drive_present_ff[sel_ff]) begin
                           rsp.disk_cmd        = DCMD_WRITE;
                           rsp.disk_unit       = sel_ff;
                           rsp.disk_sector     = cur_ff;
                           rsp.disk_byte_index = pos_ff[7:0];
                           rsp.disk_wdata      = req.wdata;
                        end
                        pos_in = pos_ff + 1'b1;
                     end
                  end
               end
               PORT_STATUS: begin
                  // Soft reset leaves the timer event in place.
                  clr       = 1'b1;
                  cmd_in    = '{default: 8'd0};
                  sense_in  = '{default: 8'd0};
                  phase_in  = PH_FREE;
                  cur_in    = 21'd0;
                  blocks_in = 8'd0;
                  ccount_in = 3'd0;
                  sel_in    = 1'b0;
                  pos_in    = '0;
                  err_in    = ERR_NONE;
                  spos_in   = 4'd0;
                  irq_in    = 1'b0;
                  drq_in    = 1'b0;
                  mask_in   = 8'd0;
                  wk_in     = WK_NONE;
                  owed_in   = 1'b0;
               end
               PORT_SELECT: begin
                  phase_in = PH_SELECT;
                  wk_in    = WK_NONE;
                  owed_in  = 1'b0;
                  pev_in   = EV_COMMAND;
                  count_in = event_delay_ff;
               end
               default: begin
                  mask_in = req.wdata;
               end
            endcase
         end
         OP_BUS_READ: begin
            case (req.port)
               PORT_DATA: begin
                  if (phase_ff == PH_READ) begin
                     if (pos_ff < POS_END) begin
                        rsp.rdata = rd_byte;
                        pos_in    = pos_ff + 1'b1;
                     end
                  end else if (phase_ff == PH_SENSE) begin
                     if (spos_ff < 4'd4) begin
                        rsp.rdata = sense_ff[spos_ff[1:0]];
                        spos_in   = spos_ff + 4'd1;
                        if (spos_in == 4'd4) begin
                           fin      = 1'b1;
                           fin_code = ERR_NONE;
                        end
                     end
                  end else if (phase_ff == PH_STATUS) begin
                     rsp.rdata = {2'b00, sel_ff, 3'b000, (err_ff != 8'd0), 1'b0};
                     phase_in  = PH_FREE;
                  end
               end
               PORT_STATUS: begin
                  sbits = {2'b00, irq_ff, drq_ff, 4'b0000};
                  if (phase_ff != PH_FREE) begin
                     sbits[3] = 1'b1;
                  end
                  if (phase_ff > PH_SELECT && phase_ff != PH_DISKWAIT) begin
                     sbits[0] = 1'b1;
                  end
                  if (phase_ff == PH_COMMAND) begin
                     sbits[2] = 1'b1;
                  end
                  if (phase_ff == PH_SENSE || phase_ff == PH_READ) begin
                     sbits[1] = 1'b1;
                  end
                  if (phase_ff == PH_STATUS) begin
                     sbits[2:1] = 2'b11;
                  end
                  rsp.rdata = sbits;
                  irq_in    = 1'b0;
               end
               default: begin
                  rsp.rdata = 8'hff;
               end
            endcase
         end
         OP_TICK: begin
            if (pev_ff == EV_COMMAND || pev_ff == EV_STATUS) begin
               if (count_ff > 16'd1) begin
                  count_in = count_ff - 16'd1;
               end else begin
                  count_in = 16'd0;
                  pev_in   = EV_NONE;
                  wk_in    = WK_NONE;
                  owed_in  = 1'b0;
                  if (pev_ff == EV_COMMAND) begin
                     phase_in  = PH_COMMAND;
                     ccount_in = 3'd0;
                  end else begin
                     phase_in      = PH_STATUS;
                     rsp.irq_pulse = mask_ff[1];
                     irq_in        = 1'b1;
                  end
               end
            end
         end
         OP_FILL: begin
            if (phase_ff == PH_DISKWAIT && (wk_ff == WK_START || wk_ff == WK_NEXT)) begin
               buf_req.we    = 1'b1;
               buf_req.waddr = req.fill_index;
               buf_req.wdata = req.fill_byte;
            end
         end
         OP_DONE: begin
            if (phase_ff == PH_DISKWAIT && wk_ff != WK_NONE) begin
               wk_in   = WK_NONE;
               owed_in = 1'b0;
               case (wk_ff)
                  WK_FORMAT: begin
                     phase_in = PH_COMMAND;
                     fin      = 1'b1;
                     fin_code = req.disk_ok ? ERR_NONE : ERR_DISK;
                  end
                  WK_START: begin
                     if (req.disk_ok) begin
                        phase_in = (cmd_ff[0] == CMD_WRITE) ? PH_WRITE : PH_READ;
                        pos_in   = '0;
                        clr      = (cmd_ff[0] == CMD_WRITE);
                        drq_in   = 1'b1;
                     end else begin
                        phase_in = PH_COMMAND;
                        clr      = 1'b1;
                        fin      = 1'b1;
                        fin_code = ERR_DISK;
                     end
                  end
                  default: begin
                     phase_in = (cmd_ff[0] == CMD_WRITE) ? PH_WRITE : PH_READ;
                     if (!req.disk_ok) begin
                        clr      = 1'b1;
                        fin      = 1'b1;
                        fin_code = ERR_DISK;
                        drq_in   = 1'b0;
                     end
                  end
               endcase
            end
         end
         default: ;
      endcase

      // End of a buffered block after the last byte was moved.
      if ((req.operation == OP_BUS_WRITE && req.port == PORT_DATA && phase_ff == PH_WRITE ||
           req.operation == OP_BUS_READ && req.port == PORT_DATA && phase_ff == PH_READ) &&
          pos_ff < POS_END && pos_in == POS_END) begin
         blocks_in = blocks_ff - 8'd1;
         if (blocks_in != 8'd0) begin
            cur_in = cur_ff + 21'd1;
            pos_in = '0;
            clr    = 1'b1;
            if (drive_present_ff[sel_ff]) begin
               phase_in = PH_DISKWAIT;
               wk_in    = WK_NEXT;
               owed_in  = 1'b1;
            end else begin
               fin      = 1'b1;
               fin_code = ERR_DISK;
               drq_in   = 1'b0;
            end
         end else begin
            fin      = 1'b1;
            fin_code = ERR_NONE;
            drq_in   = 1'b0;
         end
      end

      // Schedule the status phase.
      if (fin) begin
         err_in   = fin_code;
         pev_in   = EV_STATUS;
         count_in = event_delay_ff;
      end

      // A read request still owed goes out on a step without its own request.
      if (owed_in && rsp.disk_cmd == DCMD_NONE) begin
         owed_in         = 1'b0;
         rsp.disk_cmd    = DCMD_READ;
         rsp.disk_unit   = sel_in;
         rsp.disk_sector = cur_in;
      end

      rsp.drq     = drq_in;
      buf_req.clr = clr;
      if (!step) begin
         buf_req = '0;
      end
   end

   assign pos_nxt = step ? pos_in : pos_ff;

   // State registers, advanced once per step.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_FREE;
         cmd_ff    <= '{default: 8'd0};
         ccount_ff <= 3'd0;
         sel_ff    <= 1'b0;
         cur_ff    <= 21'd0;
         blocks_ff <= 8'd0;
         pos_ff    <= '0;
         err_ff    <= 8'd0;
         sense_ff  <= '{default: 8'd0};
         spos_ff   <= 4'd0;
         irq_ff    <= 1'b0;
         drq_ff    <= 1'b0;
         mask_ff   <= 8'd0;
         pev_ff    <= EV_NONE;
         count_ff  <= 16'd0;
         wk_ff     <= WK_NONE;
         owed_ff   <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         cmd_ff    <= cmd_in;
         ccount_ff <= ccount_in;
         sel_ff    <= sel_in;
         cur_ff    <= cur_in;
         blocks_ff <= blocks_in;
         pos_ff    <= pos_in;
         err_ff    <= err_in;
         sense_ff  <= sense_in;
         spos_ff   <= spos_in;
         irq_ff    <= irq_in;
         drq_ff    <= drq_in;
         mask_ff   <= mask_in;
         pev_ff    <= pev_in;
         count_ff  <= count_in;
         wk_ff     <= wk_in;
         owed_ff   <= owed_in;
      end
   end

endmodule

// ===== src/sasi_disk_controller_unit.sv =====
// ----------------------------------------------------------------------------
// SASI disk controller unit
// Host side of a SASI hard disk controller: bus ports, timer ticks and disk
// replies in, one result word out for each input word.
// ----------------------------------------------------------------------------
//  channel   direction  ports
//  req       in         req_valid, req_stall, req_data
//  rsp       out        rsp_valid, rsp_stall, rsp_data
//  csr       in         csr_we, csr_index, csr_wdata
//
// Each word is held in the input register and is then processed into the
// result register; one word per cycle is sustained while the result is not stalled.
// The sector buffer read is prefetched from its RAM for the current position.
// Reset is synchronous; after it the block is ready at once.
// A stalled result holds the result register and, behind it, the input one.
module sasi_disk_controller_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sdc_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sdc_pkg::rsp_type  rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [15:0]       csr_wdata
);
   import sdc_pkg::*;

   logic             in_valid_ff, in_valid_in;
   req_type          req_ff;
   logic             out_valid_ff;
   rsp_type          rsp_ff;
   rsp_type          rsp_next;
   logic             step;
   logic             req_take;
   buf_req_type      buf_req;
   logic [POS_W-1:0] pos_nxt;
   logic [7:0]       rd_byte;

   // A word moves on when the result register is free or being emptied.
   assign step      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !step;
   assign req_take  = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !step);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_data;
      end
   end

   sdc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .req       (req_ff),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rd_byte   (rd_byte),
      .buf_req   (buf_req),
      .pos_nxt   (pos_nxt),
      .rsp       (rsp_next)
   );

   sdc_buffer u_buffer (
      .clock   (clock),
      .reset   (reset),
      .buf_req (buf_req),
      .pos_nxt (pos_nxt),
      .rd_byte (rd_byte)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   // A processed word always appears in the result register.
   a_step_result: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid)
      else $error("processed word did not reach the result register");

   // The input side only stalls while it holds a word.
   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("input stalled while empty");

   // A result with no disk request carries no disk target.
   a_no_target: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.disk_cmd == DCMD_NONE) |->
         (rsp_data.disk_sector == 21'd0 && rsp_data.disk_unit == 1'b0))
      else $error("disk target without a disk request");
`endif

endmodule

// ===== dv/sasi_disk_controller_unit_tb.sv =====
// ----------------------------------------------------------------------------
// SASI disk controller unit testbench
// Drives bus accesses, timer ticks and disk replies into the controller and
// compares every result word with a behavioural model held in the bench.
// A short directed part is followed by random command sequences under
// several drive and delay settings, with random sender gaps and stalls.
// ----------------------------------------------------------------------------
module sasi_disk_controller_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sdc_pkg::*;

   // Bus phases, event kinds and disk wait kinds of the model.
   localparam logic [3:0] PH_FREE     = 4'd0;
   localparam logic [3:0] PH_SELECT   = 4'd1;
   localparam logic [3:0] PH_COMMAND  = 4'd2;
   localparam logic [3:0] PH_C2       = 4'd3;
   localparam logic [3:0] PH_SENSE    = 4'd4;
   localparam logic [3:0] PH_READ     = 4'd5;
   localparam logic [3:0] PH_WRITE    = 4'd6;
   localparam logic [3:0] PH_STATUS   = 4'd7;
   localparam logic [3:0] PH_DISKWAIT = 4'd8;
   localparam logic [1:0] EV_NONE     = 2'd0;
   localparam logic [1:0] EV_COMMAND  = 2'd1;
   localparam logic [1:0] EV_STATUS   = 2'd2;
   localparam logic [1:0] WK_NONE     = 2'd0;
   localparam logic [1:0] WK_START    = 2'd1;
   localparam logic [1:0] WK_NEXT     = 2'd2;
   localparam logic [1:0] WK_FORMAT   = 2'd3;

   // Command codes.
   localparam logic [7:0] CMD_TEST_READY = 8'h00;
   localparam logic [7:0] CMD_RECAL      = 8'h01;
   localparam logic [7:0] CMD_SENSE      = 8'h03;
   localparam logic [7:0] CMD_FMT_DRIVE  = 8'h04;
   localparam logic [7:0] CMD_FMT_TRACK  = 8'h06;
   localparam logic [7:0] CMD_READ       = 8'h08;
   localparam logic [7:0] CMD_WRITE      = 8'h0a;
   localparam logic [7:0] CMD_SEEK       = 8'h0b;
   localparam logic [7:0] CMD_C2         = 8'hc2;

   // Error codes.
   localparam logic [7:0] ERR_NONE   = 8'h00;
   localparam logic [7:0] ERR_DISK   = 8'h0f;
   localparam logic [7:0] ERR_ABSENT = 8'h7f;

   localparam int TIMEOUT_CYCLES = 400000;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_we    = 1'b0;
   logic    csr_index = 1'b0;
   logic [15:0] csr_wdata = '0;

   sasi_disk_controller_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Controller model state.
   logic [1:0]  drives_fitted;
   logic [15:0] delay_ticks;
   logic [3:0]  phase;
   logic [7:0]  cmd_bytes [6];
   int          cmd_count;
   logic        unit_sel;
   logic [20:0] sector_no;
   logic [7:0]  blocks_left;
   logic [7:0]  sector_buf [SECTOR_BYTES];
   int          buf_pos;
   logic [7:0]  err_code;
   logic [7:0]  sense_buf [4];
   int          sense_pos;
   logic        irq_flag, drq_flag;
   logic [7:0]  mask_reg;
   logic [1:0]  pending_ev;
   logic [15:0] ev_countdown;
   logic [1:0]  wait_kind;
   logic        read_owed;
   rsp_type     next_rsp;

   rsp_type expected_rsps [$];
   int      error_count = 0;
   int      cycle_count = 0;
   int      burst_left  = 0;
   bit      idle_sender = 1'b1;

   function automatic bit unit_fitted();
      return drives_fitted[unit_sel];
   endfunction

   function automatic void schedule_event(logic [1:0] ev);
      pending_ev   = ev;
      ev_countdown = delay_ticks;
   endfunction

   function automatic void finish_command(logic [7:0] err);
      err_code = err;
      schedule_event(EV_STATUS);
   endfunction

   function automatic void clear_buf();
      foreach (sector_buf[i]) sector_buf[i] = 8'h00;
   endfunction

   function automatic bit start_read(logic [1:0] kind);
      clear_buf();
      if (!unit_fitted()) return 1'b0;
      phase     = PH_DISKWAIT;
      wait_kind = kind;
      read_owed = 1'b1;
      return 1'b1;
   endfunction

   function automatic void load_address();
      sector_no   = {cmd_bytes[1][4:0], cmd_bytes[2], cmd_bytes[3]};
      blocks_left = cmd_bytes[4];
   endfunction

   function automatic void soft_reset_model();
      clear_buf();
      foreach (cmd_bytes[i]) cmd_bytes[i] = 8'h00;
      foreach (sense_buf[i]) sense_buf[i] = 8'h00;
      phase = PH_FREE;
      sector_no = '0;
      blocks_left = '0;
      cmd_count = 0;
      unit_sel = 1'b0;
      buf_pos = 0;
      err_code = ERR_NONE;
      sense_pos = 0;
      irq_flag = 1'b0;
      drq_flag = 1'b0;
      mask_reg = '0;
      wait_kind = WK_NONE;
      read_owed = 1'b0;
   endfunction

   function automatic logic [3:0] transfer_phase();
      return (cmd_bytes[0] == CMD_WRITE) ? PH_WRITE : PH_READ;
   endfunction

   function automatic void run_command();
      unit_sel = cmd_bytes[1][5];
      case (cmd_bytes[0])
         CMD_TEST_READY: finish_command(unit_fitted() ? ERR_NONE : ERR_ABSENT);
         CMD_RECAL: begin
            if (unit_fitted()) begin
               sector_no = '0;
               finish_command(ERR_NONE);
            end else begin
               finish_command(ERR_ABSENT);
            end
         end
         CMD_SENSE: begin
            phase = PH_SENSE;
            sense_buf[0] = err_code;
            sense_buf[1] = {2'b00, unit_sel, sector_no[20:16]};
            sense_buf[2] = sector_no[15:8];
            sense_buf[3] = sector_no[7:0];
            err_code = ERR_NONE;
            sense_pos = 0;
         end
         CMD_FMT_DRIVE: begin
            sector_no = '0;
            finish_command(ERR_DISK);
         end
         CMD_FMT_TRACK: begin
            load_address();
            if (unit_fitted()) begin
               clear_buf();
               phase = PH_DISKWAIT;
               wait_kind = WK_FORMAT;
               next_rsp.disk_cmd = DCMD_FORMAT;
               next_rsp.disk_unit = unit_sel;
               next_rsp.disk_sector = sector_no;
            end else begin
               finish_command(ERR_DISK);
            end
         end
         CMD_READ, CMD_WRITE: begin
            load_address();
            if (blocks_left == 0 || !start_read(WK_START)) finish_command(ERR_DISK);
         end
         CMD_SEEK: begin
            load_address();
            finish_command(ERR_NONE);
         end
         CMD_C2: begin
            phase = PH_C2;
            sense_pos = 0;
         end
         default: finish_command(ERR_NONE);
      endcase
   endfunction

   // End of one buffered block of a read or write transfer.
   function automatic void end_of_block();
      blocks_left = blocks_left - 8'd1;
      if (blocks_left != 0) begin
         sector_no = sector_no + 21'd1;
         buf_pos = 0;
         if (!start_read(WK_NEXT)) begin
            finish_command(ERR_DISK);
            drq_flag = 1'b0;
         end
      end else begin
         finish_command(ERR_NONE);
         drq_flag = 1'b0;
      end
   endfunction

   function automatic void model_bus_write(logic [1:0] port, logic [7:0] data);
      case (port)
         PORT_DATA: begin
            if (phase == PH_COMMAND) begin
               if (cmd_count < 6) begin
                  cmd_bytes[cmd_count] = data;
                  cmd_count++;
                  if (cmd_count == 6) run_command();
               end
            end else if (phase == PH_C2) begin
               if (sense_pos < 10) begin
                  sense_pos++;
                  if (sense_pos == 10) finish_command(ERR_NONE);
               end
            end else if (phase == PH_WRITE) begin
               if (buf_pos < SECTOR_BYTES) begin
                  sector_buf[buf_pos] = data;
                  if (unit_fitted()) begin
                     next_rsp.disk_cmd = DCMD_WRITE;
                     next_rsp.disk_unit = unit_sel;
                     next_rsp.disk_sector = sector_no;
                     next_rsp.disk_byte_index = buf_pos[7:0];
                     next_rsp.disk_wdata = data;
                  end
                  buf_pos++;
                  if (buf_pos == SECTOR_BYTES) end_of_block();
               end
            end
         end
         PORT_STATUS: soft_reset_model();
         PORT_SELECT: begin
            phase = PH_SELECT;
            wait_kind = WK_NONE;
            read_owed = 1'b0;
            schedule_event(EV_COMMAND);
         end
         default: mask_reg = data;
      endcase
   endfunction

   function automatic logic [7:0] model_bus_read(logic [1:0] port);
      logic [7:0] v;
      v = 8'h00;
      if (port == PORT_DATA) begin
         if (phase == PH_READ) begin
            if (buf_pos < SECTOR_BYTES) begin
               v = sector_buf[buf_pos];
               buf_pos++;
               if (buf_pos == SECTOR_BYTES) end_of_block();
            end
         end else if (phase == PH_SENSE) begin
            if (sense_pos < 4) begin
               v = sense_buf[sense_pos];
               sense_pos++;
               if (sense_pos == 4) finish_command(ERR_NONE);
            end
         end else if (phase == PH_STATUS) begin
            v = {2'b00, unit_sel, 3'b000, (err_code != 0), 1'b0};
            phase = PH_FREE;
         end
         return v;
      end
      if (port == PORT_STATUS) begin
         v = {2'b00, irq_flag, drq_flag, 4'h0};
         irq_flag = 1'b0;
         if (phase != PH_FREE) v |= 8'h08;
         if (phase > PH_SELECT && phase != PH_DISKWAIT) v |= 8'h01;
         if (phase == PH_COMMAND) v |= 8'h04;
         if (phase == PH_SENSE || phase == PH_READ) v |= 8'h02;
         if (phase == PH_STATUS) v |= 8'h06;
         return v;
      end
      return 8'hff;
   endfunction

   function automatic void model_tick();
      logic [1:0] ev;
      ev = pending_ev;
      if (ev != EV_COMMAND && ev != EV_STATUS) return;
      if (ev_countdown > 1) begin
         ev_countdown--;
         return;
      end
      ev_countdown = '0;
      pending_ev = EV_NONE;
      wait_kind = WK_NONE;
      read_owed = 1'b0;
      if (ev == EV_COMMAND) begin
         phase = PH_COMMAND;
         cmd_count = 0;
      end else begin
         phase = PH_STATUS;
         if (mask_reg[1]) next_rsp.irq_pulse = 1'b1;
         irq_flag = 1'b1;
      end
   endfunction

   function automatic void model_disk_done(logic ok);
      logic [1:0] kind;
      kind = wait_kind;
      if (phase != PH_DISKWAIT || kind == WK_NONE) return;
      wait_kind = WK_NONE;
      read_owed = 1'b0;
      if (kind == WK_FORMAT) begin
         phase = PH_COMMAND;
         finish_command(ok ? ERR_NONE : ERR_DISK);
      end else if (kind == WK_START) begin
         if (ok) begin
            phase = transfer_phase();
            buf_pos = 0;
            if (phase == PH_WRITE) clear_buf();
            drq_flag = 1'b1;
         end else begin
            phase = PH_COMMAND;
            clear_buf();
            finish_command(ERR_DISK);
         end
      end else begin
         phase = transfer_phase();
         if (!ok) begin
            clear_buf();
            finish_command(ERR_DISK);
            drq_flag = 1'b0;
         end
      end
   endfunction

   // Works out the result word that one accepted input word causes.
   function automatic rsp_type predict_result(req_type w);
      next_rsp = '0;
      case (w.operation)
         OP_BUS_WRITE: model_bus_write(w.port, w.wdata);
         OP_BUS_READ:  next_rsp.rdata = model_bus_read(w.port);
         OP_TICK:      model_tick();
         OP_FILL: begin
            if (phase == PH_DISKWAIT && (wait_kind == WK_START || wait_kind == WK_NEXT))
               sector_buf[w.fill_index] = w.fill_byte;
         end
         OP_DONE:      model_disk_done(w.disk_ok);
         default: ;
      endcase
      if (read_owed && next_rsp.disk_cmd == DCMD_NONE) begin
         read_owed = 1'b0;
         next_rsp.disk_cmd = DCMD_READ;
         next_rsp.disk_unit = unit_sel;
         next_rsp.disk_sector = sector_no;
      end
      next_rsp.drq = drq_flag;
      return next_rsp;
   endfunction

   // Result checker: each accepted word against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $error("result word with no expectation waiting: %p", rsp_data);
            error_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.rdata != want.rdata) begin
               $error("rdata: expected %0h, got %0h", want.rdata, rsp_data.rdata);
               error_count++;
            end
            if (rsp_data.irq_pulse != want.irq_pulse) begin
               $error("irq_pulse: expected %0b, got %0b", want.irq_pulse, rsp_data.irq_pulse);
               error_count++;
            end
            if (rsp_data.drq != want.drq) begin
               $error("drq: expected %0b, got %0b", want.drq, rsp_data.drq);
               error_count++;
            end
            if (rsp_data.disk_cmd != want.disk_cmd) begin
               $error("disk_cmd: expected %0d, got %0d", want.disk_cmd, rsp_data.disk_cmd);
               error_count++;
            end
            if (rsp_data.disk_unit != want.disk_unit) begin
               $error("disk_unit: expected %0d, got %0d", want.disk_unit, rsp_data.disk_unit);
               error_count++;
            end
            if (rsp_data.disk_sector != want.disk_sector) begin
               $error("disk_sector: expected %0h, got %0h",
                      want.disk_sector, rsp_data.disk_sector);
               error_count++;
            end
            if (rsp_data.disk_byte_index != want.disk_byte_index) begin
               $error("disk_byte_index: expected %0h, got %0h",
                      want.disk_byte_index, rsp_data.disk_byte_index);
               error_count++;
            end
            if (rsp_data.disk_wdata != want.disk_wdata) begin
               $error("disk_wdata: expected %0h, got %0h", want.disk_wdata, rsp_data.disk_wdata);
               error_count++;
            end
         end
      end
   end

   // Receiver stall pattern: a stall share of 0, 25, 50 or 75 percent, redrawn from the cycle count.
   always @(posedge clock) begin
      int unsigned stall_pct;
      if (cycle_count % 64 == 0) stall_pct = $urandom_range(0, 3) * 25;
      rsp_stall <= ($urandom_range(1, 100) <= stall_pct);
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > TIMEOUT_CYCLES) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_word(input req_type w);
      req_data  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      expected_rsps.push_back(predict_result(w));
      // Bursts of random length, separated by random gaps while the sender may idle.
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if (idle_sender) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic send_op(input logic [2:0] op, input logic [1:0] port,
                          input logic [7:0] data);
      req_type w;
      w.operation  = op;
      w.port       = port;
      w.wdata      = data;
      w.fill_index = 8'($urandom);
      w.fill_byte  = 8'($urandom);
      w.disk_ok    = 1'($urandom);
      send_word(w);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_csr(input logic index, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (index == CSR_DRIVE_PRESENT) drives_fitted = value[1:0];
      else delay_ticks = value;
   endtask

   // Chooses the next word from the model's phase so that most sequences
   // are well formed, with a share of arbitrary words mixed in.
   task automatic send_guided();
      req_type w;
      logic [7:0] pick;
      w = req_type'({$urandom, $urandom});
      if ($urandom_range(1, 100) <= 8) begin
         // Arbitrary word; soft resets kept rare.
         if (w.operation == OP_BUS_WRITE && w.port == PORT_STATUS && $urandom_range(0, 3) != 0)
            w.port = PORT_MASK;
         send_word(w);
         return;
      end
      w.disk_ok = ($urandom_range(1, 10) != 1);
      case (phase)
         PH_FREE: begin
            w.operation = OP_BUS_WRITE;
            w.port = PORT_SELECT;
         end
         PH_COMMAND: begin
            if (cmd_count < 6) begin
               w.operation = OP_BUS_WRITE;
               w.port = PORT_DATA;
               if (cmd_count == 0) begin
                  case ($urandom_range(0, 10))
                     0: pick = CMD_TEST_READY;
                     1: pick = CMD_RECAL;
                     2: pick = CMD_SENSE;
                     3: pick = CMD_FMT_DRIVE;
                     4: pick = CMD_FMT_TRACK;
                     5, 6: pick = CMD_READ;
                     7, 8: pick = CMD_WRITE;
                     9: pick = CMD_SEEK;
                     default: pick = ($urandom_range(0, 1) != 0) ? CMD_C2 : 8'($urandom);
                  endcase
                  w.wdata = pick;
               end else if (cmd_count == 4) begin
                  case ($urandom_range(0, 19))
                     0: w.wdata = 8'h00;
                     1, 2, 3: w.wdata = 8'd2;
                     4: w.wdata = 8'd3;
                     default: w.wdata = 8'd1;
                  endcase
               end
            end else begin
               w.operation = OP_TICK;
            end
         end
         PH_C2: begin
            w.operation = (sense_pos < 10 || $urandom_range(0, 1)) ? OP_BUS_WRITE : OP_TICK;
            w.port = PORT_DATA;
         end
         PH_SENSE: begin
            w.operation = (sense_pos < 4 || $urandom_range(0, 3) == 0) ? OP_BUS_READ : OP_TICK;
            w.port = PORT_DATA;
         end
         PH_READ: begin
            w.operation = (buf_pos < SECTOR_BYTES) ? OP_BUS_READ : OP_TICK;
            w.port = ($urandom_range(0, 15) == 0) ? PORT_STATUS : PORT_DATA;
         end
         PH_WRITE: begin
            w.operation = (buf_pos < SECTOR_BYTES) ? OP_BUS_WRITE : OP_TICK;
            w.port = PORT_DATA;
         end
         PH_STATUS: begin
            w.operation = OP_BUS_READ;
            w.port = ($urandom_range(0, 4) == 0) ? PORT_STATUS : PORT_DATA;
         end
         PH_DISKWAIT: begin
            if (wait_kind == WK_NONE) w.operation = OP_TICK;
            else if (wait_kind != WK_FORMAT && $urandom_range(0, 9) < 6) w.operation = OP_FILL;
            else if ($urandom_range(0, 5) == 0) w.operation = OP_BUS_READ;
            else w.operation = OP_DONE;
         end
         default: w.operation = OP_TICK;
      endcase
      // A finished command still waits for its status phase.
      if (pending_ev == EV_STATUS && phase != PH_STATUS && $urandom_range(0, 1) != 0)
         w.operation = OP_TICK;
      send_word(w);
   endtask

   // Extremes of the fields, every port, the sense overrun and ignored words.
   task automatic test_directed();
      req_type w;
      write_csr(CSR_DRIVE_PRESENT, 16'd3);
      write_csr(CSR_EVENT_DELAY, 16'd1);
      send_op(OP_BUS_WRITE, PORT_MASK, 8'hff);
      send_op(OP_BUS_READ, PORT_SELECT, 8'h00);
      send_op(OP_BUS_READ, PORT_MASK, 8'h00);
      send_op(OP_BUS_READ, PORT_DATA, 8'h00);
      send_op(OP_BUS_WRITE, PORT_SELECT, 8'hff);
      send_op(OP_TICK, PORT_DATA, 8'h00);
      send_op(OP_BUS_READ, PORT_STATUS, 8'h00);
      send_op(OP_BUS_WRITE, PORT_DATA, CMD_SENSE);
      send_op(OP_BUS_WRITE, PORT_DATA, 8'hff);
      send_op(OP_BUS_WRITE, PORT_DATA, 8'hff);
      send_op(OP_BUS_WRITE, PORT_DATA, 8'hff);
      send_op(OP_BUS_WRITE, PORT_DATA, 8'hff);
      send_op(OP_BUS_WRITE, PORT_DATA, 8'h00);
      repeat (5) send_op(OP_BUS_READ, PORT_DATA, 8'h00);
      send_op(OP_TICK, PORT_DATA, 8'h00);
      send_op(OP_BUS_READ, PORT_STATUS, 8'h00);
      send_op(OP_BUS_READ, PORT_DATA, 8'h00);
      // Undefined operations and disk replies nobody waits for.
      w = '1;
      for (int op = 5; op <= 7; op++) begin
         w.operation = 3'(op);
         send_word(w);
      end
      w = '0;
      w.operation = OP_FILL;
      send_word(w);
      w.operation = OP_DONE;
      send_word(w);
      wait_drained();
   endtask

   task automatic test_random(input logic [1:0] fitted, input logic [15:0] delay, input int n);
      write_csr(CSR_DRIVE_PRESENT, {14'd0, fitted});
      write_csr(CSR_EVENT_DELAY, delay);
      idle_sender = 1'b1;
      for (int i = 0; i < n; i++) begin
         if (i == n / 2) begin
            // Sender holds off until everything has come back.
            req_valid <= 1'b0;
            @(posedge clock);
            while (expected_rsps.size() != 0) @(posedge clock);
            idle_sender = 1'b0;
         end
         send_guided();
      end
      wait_drained();
   endtask

   // Longest delay: the event is armed, counted a little and left pending across a soft reset.
   task automatic test_long_delay();
      write_csr(CSR_EVENT_DELAY, 16'hffff);
      send_op(OP_BUS_WRITE, PORT_SELECT, 8'h00);
      repeat (6) send_op(OP_TICK, PORT_DATA, 8'h00);
      send_op(OP_BUS_READ, PORT_STATUS, 8'h00);
      send_op(OP_BUS_WRITE, PORT_STATUS, 8'h00);
      wait_drained();
   endtask

   initial begin
      drives_fitted = 2'd0;
      delay_ticks   = 16'd10;
      soft_reset_model();
      pending_ev    = EV_NONE;
      ev_countdown  = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(2'd3, 16'd1, 500);
      test_random(2'd1, 16'd2, 280);
      test_random(2'd2, 16'd3, 280);
      test_random(2'd0, 16'd1, 120);
      test_long_delay();
      test_random(2'd3, 16'($urandom_range(1, 4)), 270);

      wait_drained();
      repeat (10) @(posedge clock);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         if (expected_rsps.size() != 0)
            $error("%0d expected result words never arrived", expected_rsps.size());
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/sdc_pkg.sv
src/sdc_buffer.sv
src/sdc_core.sv
src/sasi_disk_controller_unit.sv
dv/sasi_disk_controller_unit_tb.sv
